// ===== sv/fmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fmc_pkg;

	localparam int FRAC_BITS   = 20;
	localparam int FIELD_WIDTH = 24;

	localparam int GAIN_W = 16;
	localparam int GRAY_W = 8;
	localparam int PIX_W  = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	// square root: one result bit per stage
	localparam int ROOT_W      = FIELD_WIDTH;
	localparam int RAD_W       = 2 * FIELD_WIDTH;
	localparam int REM_W       = ROOT_W + 2;
	localparam int SQRT_STAGES = ROOT_W;

	// unsigned channel: gain * root, then base and rounding
	localparam int PROD_W  = GAIN_W + ROOT_W;
	localparam int SUM_W   = ((PROD_W > GRAY_W + FRAC_BITS) ? PROD_W : GRAY_W + FRAC_BITS) + 1;
	// signed channel: gain * rho, then base and rounding
	localparam int GPROD_W = GAIN_W + 1 + FIELD_WIDTH;
	localparam int GSUM_W  = ((GPROD_W > GRAY_W + FRAC_BITS + 1) ?
	                          GPROD_W : GRAY_W + FRAC_BITS + 1) + 1;

	localparam logic [FRAC_BITS-1:0] HALF_ULP = {1'b1, {(FRAC_BITS-1){1'b0}}};

	// three front stages, the root stages, product stage, output register
	localparam int LATENCY = 3 + SQRT_STAGES + 2;

	typedef enum logic [1:0] {
		CELL_ORDINARY = 2'd0,
		CELL_METAL    = 2'd1,
		CELL_BOUNDARY = 2'd2,
		CELL_BORDER   = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EFIELD_GAIN  = 3'd0,
		REG_CHARGE_GAIN  = 3'd1,
		REG_CURRENT_GAIN = 3'd2,
		REG_METAL_GRAY   = 3'd3,
		REG_BORDER_GRAY  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		kind_t                          cell_kind;
		logic signed [FIELD_WIDTH-1:0]  efield_x;
		logic signed [FIELD_WIDTH-1:0]  efield_y;
		logic signed [FIELD_WIDTH-1:0]  charge_density;
		logic signed [FIELD_WIDTH-1:0]  current_x;
		logic signed [FIELD_WIDTH-1:0]  current_y;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [GAIN_W-1:0] efield_gain;
		logic [GAIN_W-1:0] charge_gain;
		logic [GAIN_W-1:0] current_gain;
		logic [GRAY_W-1:0] metal_gray;
		logic [GRAY_W-1:0] border_gray;
	} cfg_t;

	// words that ride alongside the root pipeline
	typedef struct packed {
		logic [GRAY_W-1:0] base;
		logic [PIX_W-1:0]  green;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_st_t;

	function automatic logic [FIELD_WIDTH-1:0] abs_field(logic signed [FIELD_WIDTH-1:0] v);
		logic [FIELD_WIDTH-1:0] neg;
		neg = unsigned'(-v);
		return v[FIELD_WIDTH-1] ? neg : unsigned'(v);
	endfunction

	// one digit of the restoring square root
	function automatic sqrt_st_t sqrt_step(logic [REM_W-1:0] rem, logic [ROOT_W-1:0] root,
	                                       logic [1:0] pair);
		logic [REM_W+1:0] acc;
		logic [REM_W+1:0] trial;
		sqrt_st_t         nxt;
		acc   = {rem, pair};
		trial = {2'b00, root, 2'b01};
		if (acc >= trial) begin
			nxt.rem  = REM_W'(acc - trial);
			nxt.root = {root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = acc[REM_W-1:0];
			nxt.root = {root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	function automatic logic [PIX_W-1:0] sat_u(logic [SUM_W-1:0] t);
		if (|t[SUM_W-1:FRAC_BITS+PIX_W])
			return {PIX_W{1'b1}};
		return t[FRAC_BITS+PIX_W-1:FRAC_BITS];
	endfunction

	function automatic logic [PIX_W-1:0] sat_s(logic signed [GSUM_W-1:0] t);
		if (t[GSUM_W-1])
			return '0;
		if (|t[GSUM_W-2:FRAC_BITS+PIX_W])
			return {PIX_W{1'b1}};
		return t[FRAC_BITS+PIX_W-1:FRAC_BITS];
	endfunction

endpackage

`default_nettype wire

// ===== sv/fmc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fmc_cfg_regs (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [fmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [fmc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output fmc_pkg::cfg_t                   cfg
);
	import fmc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.efield_gain  <= GAIN_W'(2000);
			cfg_q.charge_gain  <= GAIN_W'(200);
			cfg_q.current_gain <= GAIN_W'(200);
			cfg_q.metal_gray   <= GRAY_W'(100);
			cfg_q.border_gray  <= GRAY_W'(150);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_EFIELD_GAIN:  cfg_q.efield_gain  <= cfg_data[GAIN_W-1:0];
				REG_CHARGE_GAIN:  cfg_q.charge_gain  <= cfg_data[GAIN_W-1:0];
				REG_CURRENT_GAIN: cfg_q.current_gain <= cfg_data[GAIN_W-1:0];
				REG_METAL_GRAY:   cfg_q.metal_gray   <= cfg_data[GRAY_W-1:0];
				REG_BORDER_GRAY:  cfg_q.border_gray  <= cfg_data[GRAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/fmc_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fmc_isqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          vld_in,
	input  wire  fmc_pkg::side_t         side_in,
	input  wire  [fmc_pkg::RAD_W-1:0]    rad_e,
	input  wire  [fmc_pkg::RAD_W-1:0]    rad_a,
	output logic                         vld_out,
	output fmc_pkg::side_t               side_out,
	output logic [fmc_pkg::ROOT_W-1:0]   root_e,
	output logic [fmc_pkg::ROOT_W-1:0]   root_a
);
	import fmc_pkg::*;

	logic              vld_s    [SQRT_STAGES];
	side_t             side_s   [SQRT_STAGES];
	logic [ROOT_W-1:0] root_e_s [SQRT_STAGES];
	logic [ROOT_W-1:0] root_a_s [SQRT_STAGES];
	logic [REM_W-1:0]  rem_e_s  [SQRT_STAGES-1];
	logic [REM_W-1:0]  rem_a_s  [SQRT_STAGES-1];
	logic [RAD_W-1:0]  rad_e_s  [SQRT_STAGES-1];
	logic [RAD_W-1:0]  rad_a_s  [SQRT_STAGES-1];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic              vld_i;
		side_t             side_i;
		logic [ROOT_W-1:0] root_e_i, root_a_i;
		logic [REM_W-1:0]  rem_e_i, rem_a_i;
		logic [RAD_W-1:0]  rad_e_i, rad_a_i;
		sqrt_st_t          nxt_e, nxt_a;

		if (k == 0) begin : g_first
			assign vld_i    = vld_in;
			assign side_i   = side_in;
			assign root_e_i = '0;
			assign root_a_i = '0;
			assign rem_e_i  = '0;
			assign rem_a_i  = '0;
			assign rad_e_i  = rad_e;
			assign rad_a_i  = rad_a;
		end else begin : g_next
			assign vld_i    = vld_s[k-1];
			assign side_i   = side_s[k-1];
			assign root_e_i = root_e_s[k-1];
			assign root_a_i = root_a_s[k-1];
			assign rem_e_i  = rem_e_s[k-1];
			assign rem_a_i  = rem_a_s[k-1];
			assign rad_e_i  = rad_e_s[k-1];
			assign rad_a_i  = rad_a_s[k-1];
		end

		// radicand digits are taken from the top, two bits a stage
		assign nxt_e = sqrt_step(rem_e_i, root_e_i, rad_e_i[RAD_W-1-2*k -: 2]);
		assign nxt_a = sqrt_step(rem_a_i, root_a_i, rad_a_i[RAD_W-1-2*k -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else
				vld_s[k] <= vld_i;
		end

		always_ff @(posedge clk) begin
			side_s[k]   <= side_i;
			root_e_s[k] <= nxt_e.root;
			root_a_s[k] <= nxt_a.root;
		end

		if (k < SQRT_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_e_s[k] <= nxt_e.rem;
				rem_a_s[k] <= nxt_a.rem;
				rad_e_s[k] <= rad_e_i;
				rad_a_s[k] <= rad_a_i;
			end
		end
	end

	assign vld_out  = vld_s[SQRT_STAGES-1];
	assign side_out = side_s[SQRT_STAGES-1];
	assign root_e   = root_e_s[SQRT_STAGES-1];
	assign root_a   = root_a_s[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/field_magnitude_colorizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                        direction  handshake
// item      start, busy, item              in         taken when start and not busy
// pixel     done, pixel                    out        valid for the one cycle done is high
// config    cfg_we, cfg_index, cfg_data    in         written when cfg_we is high
//
// one word is taken every cycle; busy stays low
// each pixel passes through three front stages (abs, squares, sums),
// 24 root stages (one result bit per stage), the gain product and the output register
// reset clears the valid bits of every stage and loads the default register values
// the receiver cannot stall, so the pipeline never holds

module field_magnitude_colorizer (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire  fmc_pkg::item_t            item,
	output logic                            done,
	output fmc_pkg::pixel_t                 pixel,
	input  wire                             cfg_we,
	input  wire  [fmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [fmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fmc_pkg::*;

	cfg_t cfg;

	fmc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign busy = 1'b0;

	// stage 1: base level and magnitudes of the components
	logic [GRAY_W-1:0] base;

	always_comb begin
		case (item.cell_kind)
			CELL_METAL, CELL_BOUNDARY: base = cfg.metal_gray;
			CELL_BORDER:               base = cfg.border_gray;
			default:                   base = '0;
		endcase
	end

	logic                          vld_s1;
	logic [GRAY_W-1:0]             base_s1;
	logic [FIELD_WIDTH-1:0]        abs_ex_s1, abs_ey_s1, abs_ax_s1, abs_ay_s1;
	logic signed [FIELD_WIDTH-1:0] rho_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		base_s1   <= base;
		abs_ex_s1 <= abs_field(item.efield_x);
		abs_ey_s1 <= abs_field(item.efield_y);
		abs_ax_s1 <= abs_field(item.current_x);
		abs_ay_s1 <= abs_field(item.current_y);
		rho_s1    <= item.charge_density;
	end

	// stage 2: squares and the charge product
	logic                      vld_s2;
	logic [GRAY_W-1:0]         base_s2;
	logic [RAD_W-1:0]          sq_ex_s2, sq_ey_s2, sq_ax_s2, sq_ay_s2;
	logic signed [GPROD_W-1:0] prod_g_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		base_s2   <= base_s1;
		sq_ex_s2  <= RAD_W'(abs_ex_s1) * RAD_W'(abs_ex_s1);
		sq_ey_s2  <= RAD_W'(abs_ey_s1) * RAD_W'(abs_ey_s1);
		sq_ax_s2  <= RAD_W'(abs_ax_s1) * RAD_W'(abs_ax_s1);
		sq_ay_s2  <= RAD_W'(abs_ay_s1) * RAD_W'(abs_ay_s1);
		prod_g_s2 <= GPROD_W'($signed({1'b0, cfg.charge_gain})) * GPROD_W'(rho_s1);
	end

	// stage 3: radicands and the finished green channel
	logic signed [GSUM_W-1:0] g_base, g_sum;

	always_comb begin
		g_base = $signed(GSUM_W'(base_s2) << FRAC_BITS);
		g_sum  = GSUM_W'(prod_g_s2) + g_base + $signed(GSUM_W'(HALF_ULP));
	end

	logic             vld_s3;
	side_t            side_s3;
	logic [RAD_W-1:0] rad_e_s3, rad_a_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		side_s3.base  <= base_s2;
		side_s3.green <= sat_s(g_sum);
		rad_e_s3      <= sq_ex_s2 + sq_ey_s2;
		rad_a_s3      <= sq_ax_s2 + sq_ay_s2;
	end

	logic              vld_sq;
	side_t             side_sq;
	logic [ROOT_W-1:0] root_e, root_a;

	fmc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s3),
		.side_in  (side_s3),
		.rad_e    (rad_e_s3),
		.rad_a    (rad_a_s3),
		.vld_out  (vld_sq),
		.side_out (side_sq),
		.root_e   (root_e),
		.root_a   (root_a)
	);

	// stage 4: gain times magnitude
	logic              vld_s4;
	side_t             side_s4;
	logic [PROD_W-1:0] prod_r_s4, prod_b_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= vld_sq;
	end

	always_ff @(posedge clk) begin
		side_s4   <= side_sq;
		prod_r_s4 <= PROD_W'(cfg.efield_gain) * PROD_W'(root_e);
		prod_b_s4 <= PROD_W'(cfg.current_gain) * PROD_W'(root_a);
	end

	// stage 5: base, rounding and saturation into the output register
	logic [SUM_W-1:0] u_base, r_sum, b_sum;

	always_comb begin
		u_base = SUM_W'(side_s4.base) << FRAC_BITS;
		r_sum  = SUM_W'(prod_r_s4) + u_base + SUM_W'(HALF_ULP);
		b_sum  = SUM_W'(prod_b_s4) + u_base + SUM_W'(HALF_ULP);
	end

	logic   done_q;
	pixel_t pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_s4;
	end

	always_ff @(posedge clk) begin
		pixel_q.red   <= sat_u(r_sum);
		pixel_q.green <= side_s4.green;
		pixel_q.blue  <= sat_u(b_sum);
	end

	assign done  = done_q;
	assign pixel = pixel_q;

	// every accepted word comes out as a pixel, and nothing else does
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted word produced no pixel");

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("pixel without an accepted word");

	// an ordinary cell with no field must give a black red channel
	a_black_red: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cell_kind == CELL_ORDINARY &&
		 item.efield_x == '0 && item.efield_y == '0) |-> ##LATENCY (pixel.red == '0))
		else $error("red channel not black for an ordinary cell without field");

endmodule

`default_nettype wire
